// ===== hdl/assert_macros.svh =====
// Assertion helpers included by the controller core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is asserted.
`define AEGS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form built on the macro above.
`define AEGS_ASSERT_IMPL(label, ante, cons, msg) \
  `AEGS_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication form built on the first macro.
`define AEGS_ASSERT_NEXT(label, ante, cons, msg) \
  `AEGS_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== hdl/aegs_pkg.sv =====
package aegs_pkg;

  // Fraction bits of the luma fixed-point format.
  localparam int LumaFracBits = 8;

  localparam int LumaW  = 16;
  localparam int IsoW   = 16;
  localparam int ExpW   = 25;
  localparam int CfgW   = 30;
  localparam int ErrW   = 24;
  localparam int QuoW   = 32;
  localparam int RootW  = 20;
  localparam int RadW   = 2 * RootW;
  localparam int SremW  = RootW + 2;
  localparam int ProdW  = IsoW + RootW;
  localparam int AluW   = 24;
  localparam int CntW   = 5;
  localparam int CfgIdxW = 3;
  localparam int SettleW = 3;

  localparam int InW    = 16;
  localparam int OutUsedW = IsoW + ExpW + 1;
  localparam int OutW   = 48;
  localparam int OutPadW = OutW - OutUsedW;

  localparam logic [LumaW-1:0] LumaHalf    = LumaW'(1 << (LumaFracBits - 1));
  localparam logic [ExpW-1:0]  MainsNs     = 25'd10_000_000;
  localparam logic [ExpW-1:0]  ExpoCapNs   = 25'd33_000_000;
  localparam logic [ErrW-1:0]  BandLo      = 24'd60948;
  localparam logic [ErrW-1:0]  BandHi      = 24'd70124;
  localparam logic [ErrW-1:0]  ErrMax      = 24'hFF_FFFF;
  localparam logic [IsoW-1:0]  IsoStart    = 16'd400;
  localparam logic [SettleW-1:0] SettleItems = 3'd6;
  localparam logic [LumaW-1:0] TargetReset = 16'd30720;

  typedef enum logic [CfgIdxW-1:0] {
    CfgIsoMin = 3'd0,
    CfgIsoMax = 3'd1,
    CfgExpMin = 3'd2,
    CfgExpMax = 3'd3,
    CfgTarget = 3'd4
  } cfg_idx_e;

  // Result of the shared subtract-and-compare unit.
  typedef struct packed {
    logic            ge;
    logic [AluW-1:0] diff;
  } alu_res_t;

endpackage

// ===== hdl/aegs_alu.sv =====
module aegs_alu (
  input  logic [aegs_pkg::AluW-1:0] a_i,
  input  logic [aegs_pkg::AluW-1:0] b_i,
  output aegs_pkg::alu_res_t        res_o
);
  import aegs_pkg::*;

  logic [AluW:0] full;

  // One subtraction gives both the difference and the a >= b decision.
  assign full       = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.ge   = ~full[AluW];
  assign res_o.diff = full[AluW-1:0];

endmodule

// ===== hdl/auto_exposure_gain_step_core.sv =====
// Auto exposure and gain controller, stepped once per frame. Each input item
// is the mean luma of one frame (unsigned 8.8); each item returns exactly one
// result item holding the current ISO gain, the exposure time in nanoseconds
// and a flag that tells whether either changed since the previous result.
// The block takes one item at a time and deasserts s_axis_tready_o until the
// item has been worked off. An item that is skipped (limits not set, a dark
// frame, or a frame inside the settling window) passes through an upkeep step
// and a step that loads the result. An item whose error lands inside the dead
// band takes the upkeep step, a 32-step restoring division for the luma error,
// one band check and the load. An item that is acted on runs, after the
// division and the band check, a 20-step square root through the same single
// shared 24-bit subtract-and-compare unit, then multiplies, rounds and clamps
// the gain, steps the exposure and clamps it again, and loads the result in a
// last step. s_axis_tready_o rises in the cycle the result is loaded, so a new
// item is accepted only once the previous one is through. The result sits
// in an output register, so the next item can be accepted while it waits
// for m_axis_tready_i; an item that finishes while that register is still
// full waits in its last step until the register frees. Configuration
// registers are written through the cfg port and must only change while no
// item is in flight.
module auto_exposure_gain_step_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream. tdata: mean_luma[15:0].
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [aegs_pkg::InW-1:0]      s_axis_tdata_i,
  // Result stream. tdata: iso[15:0], exposure_ns[40:16], changed[41], zeros.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [aegs_pkg::OutW-1:0]     m_axis_tdata_o,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [aegs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [aegs_pkg::CfgW-1:0]     cfg_wdata_i
);
  import aegs_pkg::*;

`include "assert_macros.svh"

  typedef enum logic [3:0] {
    StIdle,
    StUpkeep,
    StDiv,
    StBand,
    StSqrt,
    StMul,
    StRound,
    StStep,
    StFix,
    StDone
  } state_e;

  // Clamp a candidate gain into [lo, hi]; the lower limit wins on overlap.
  function automatic logic [IsoW-1:0] clamp_iso(input logic [RootW-1:0] v,
                                                input logic [IsoW-1:0]  lo,
                                                input logic [IsoW-1:0]  hi);
    logic [RootW-1:0] t;
    t = (v > RootW'(hi)) ? RootW'(hi) : v;
    if (t < RootW'(lo)) t = RootW'(lo);
    return t[IsoW-1:0];
  endfunction

  // Clamp an exposure into [lo, hi], then apply the hard frame-time cap.
  function automatic logic [ExpW-1:0] clamp_exp(input logic [CfgW-1:0] v,
                                                input logic [CfgW-1:0] lo,
                                                input logic [CfgW-1:0] hi);
    logic [CfgW-1:0] t;
    t = (v > hi) ? hi : v;
    if (t < lo) t = lo;
    if (t > CfgW'(ExpoCapNs)) t = CfgW'(ExpoCapNs);
    return t[ExpW-1:0];
  endfunction

  // Configuration registers.
  logic [IsoW-1:0]  iso_min_q, iso_max_q;
  logic [CfgW-1:0]  exp_min_q, exp_max_q;
  logic [LumaW-1:0] target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_min_q <= '0;
      iso_max_q <= '0;
      exp_min_q <= '0;
      exp_max_q <= '0;
      target_q  <= TargetReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIsoMin: iso_min_q <= cfg_wdata_i[IsoW-1:0];
        CfgIsoMax: iso_max_q <= cfg_wdata_i[IsoW-1:0];
        CfgExpMin: exp_min_q <= cfg_wdata_i;
        CfgExpMax: exp_max_q <= cfg_wdata_i;
        CfgTarget: target_q  <= cfg_wdata_i[LumaW-1:0];
        default: ;
      endcase
    end
  end

  // Controller state and datapath registers.
  state_e              state_q, state_d;
  logic [LumaW-1:0]    luma_q, luma_d;
  logic [IsoW-1:0]     gain_q, gain_d, prev_gain_q, prev_gain_d;
  logic [ExpW-1:0]     exp_q, exp_d, prev_exp_q, prev_exp_d;
  logic [SettleW-1:0]  settle_q, settle_d;
  logic                dirty_q, dirty_d;
  logic [LumaW-1:0]    rem_q, rem_d;
  logic [QuoW-1:0]     div_q, div_d;
  logic [ErrW-1:0]     err_q, err_d;
  logic [SremW-1:0]    sr_q, sr_d;
  logic [RadW-1:0]     sqv_q, sqv_d;
  logic [RootW-1:0]    root_q, root_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [IsoW-1:0]     out_iso_q, out_iso_d;
  logic [ExpW-1:0]     out_exp_q, out_exp_d;
  logic                out_chg_q, out_chg_d;

  // Shared subtract-and-compare unit: division steps, then square root steps.
  logic [AluW-1:0] alu_a, alu_b;
  alu_res_t        alu_res;

  always_comb begin
    if (state_q == StDiv) begin
      alu_a = AluW'({rem_q, div_q[QuoW-1]});
      alu_b = AluW'(luma_q);
    end else begin
      alu_a = {sr_q, sqv_q[RadW-1 -: 2]};
      alu_b = AluW'({root_q, 2'b01});
    end
  end

  aegs_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  logic                out_free;
  logic                skip_item;
  logic [SettleW-1:0]  settle_dec;
  logic [ErrW-1:0]     err_sat;
  logic [ProdW-1:0]    prod_rnd;
  logic [ExpW:0]       exp_sum;

  assign out_free = ~out_valid_q | m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    luma_d      = luma_q;
    gain_d      = gain_q;
    exp_d       = exp_q;
    prev_gain_d = prev_gain_q;
    prev_exp_d  = prev_exp_q;
    settle_d    = settle_q;
    dirty_d     = dirty_q;
    rem_d       = rem_q;
    div_d       = div_q;
    err_d       = err_q;
    sr_d        = sr_q;
    sqv_d       = sqv_q;
    root_d      = root_q;
    prod_d      = prod_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    out_iso_d   = out_iso_q;
    out_exp_d   = out_exp_q;
    out_chg_d   = out_chg_q;

    skip_item  = (iso_max_q == '0) || (exp_max_q == '0) || (luma_q <= LumaHalf);
    settle_dec = (settle_q != '0) ? settle_q - 1'b1 : settle_q;
    err_sat    = (div_q > QuoW'(ErrMax)) ? ErrMax : div_q[ErrW-1:0];
    prod_rnd   = prod_q + ProdW'(1 << 15);
    exp_sum    = {1'b0, exp_q} + {1'b0, MainsNs};

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          luma_d  = s_axis_tdata_i[LumaW-1:0];
          state_d = StUpkeep;
        end
      end

      StUpkeep: begin
        // Limit upkeep runs on every item and never marks a change.
        if (iso_max_q != '0) begin
          gain_d = clamp_iso((gain_q == '0) ? RootW'(IsoStart) : RootW'(gain_q),
                             iso_min_q, iso_max_q);
        end
        if (exp_max_q != '0) begin
          exp_d = clamp_exp(CfgW'(exp_q), exp_min_q, exp_max_q);
        end
        prev_gain_d = gain_d;
        prev_exp_d  = exp_d;
        if (skip_item) begin
          state_d = StDone;
        end else if (settle_dec != '0) begin
          settle_d = settle_dec;
          state_d  = StDone;
        end else begin
          settle_d = SettleItems;
          rem_d    = '0;
          div_d    = {target_q, 16'b0};
          cnt_d    = CntW'(QuoW - 1);
          state_d  = StDiv;
        end
      end

      StDiv: begin
        // Restoring division: one quotient bit per cycle, MSB first.
        rem_d = alu_res.ge ? alu_res.diff[LumaW-1:0] : alu_a[LumaW-1:0];
        div_d = {div_q[QuoW-2:0], alu_res.ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = StBand;
      end

      StBand: begin
        err_d = err_sat;
        if (err_sat > BandLo && err_sat < BandHi) begin
          state_d = StDone;
        end else begin
          sr_d    = '0;
          sqv_d   = {err_sat, 16'b0};
          root_d  = '0;
          cnt_d   = CntW'(RootW - 1);
          state_d = StSqrt;
        end
      end

      StSqrt: begin
        // Digit-by-digit square root: one root bit per cycle.
        sr_d   = alu_res.ge ? alu_res.diff[SremW-1:0] : alu_a[SremW-1:0];
        root_d = {root_q[RootW-2:0], alu_res.ge};
        sqv_d  = {sqv_q[RadW-3:0], 2'b00};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = StMul;
      end

      StMul: begin
        prod_d  = ProdW'(gain_q) * ProdW'(root_q);
        state_d = StRound;
      end

      StRound: begin
        // Round half up, then clamp into the gain limits.
        gain_d  = clamp_iso(prod_rnd[ProdW-1:16], iso_min_q, iso_max_q);
        state_d = StStep;
      end

      StStep: begin
        // With the gain pinned at a limit, the exposure takes the step.
        if (gain_q >= iso_max_q && err_q >= BandHi) begin
          exp_d = (exp_sum > {1'b0, ExpoCapNs}) ? ExpoCapNs : exp_sum[ExpW-1:0];
        end else if (gain_q <= iso_min_q && err_q <= BandLo) begin
          exp_d = (exp_q > MainsNs) ? exp_q - MainsNs : exp_q >> 1;
        end
        state_d = StFix;
      end

      StFix: begin
        if (exp_max_q != '0) begin
          exp_d = clamp_exp(CfgW'(exp_q), exp_min_q, exp_max_q);
        end
        if (gain_q != prev_gain_q || exp_d != prev_exp_q) dirty_d = 1'b1;
        state_d = StDone;
      end

      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_iso_d   = gain_q;
          out_exp_d   = exp_q;
          out_chg_d   = dirty_q;
          dirty_d     = 1'b0;
          state_d     = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      luma_q      <= '0;
      gain_q      <= '0;
      exp_q       <= MainsNs;
      prev_gain_q <= '0;
      prev_exp_q  <= '0;
      settle_q    <= '0;
      dirty_q     <= 1'b1;
      rem_q       <= '0;
      div_q       <= '0;
      err_q       <= '0;
      sr_q        <= '0;
      sqv_q       <= '0;
      root_q      <= '0;
      prod_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_iso_q   <= '0;
      out_exp_q   <= '0;
      out_chg_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      luma_q      <= luma_d;
      gain_q      <= gain_d;
      exp_q       <= exp_d;
      prev_gain_q <= prev_gain_d;
      prev_exp_q  <= prev_exp_d;
      settle_q    <= settle_d;
      dirty_q     <= dirty_d;
      rem_q       <= rem_d;
      div_q       <= div_d;
      err_q       <= err_d;
      sr_q        <= sr_d;
      sqv_q       <= sqv_d;
      root_q      <= root_d;
      prod_q      <= prod_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_iso_q   <= out_iso_d;
      out_exp_q   <= out_exp_d;
      out_chg_q   <= out_chg_d;
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OutPadW{1'b0}}, out_chg_q, out_exp_q, out_iso_q};

  `AEGS_ASSERT(a_settle_range, settle_q <= SettleItems, "settle count out of range")
  `AEGS_ASSERT(a_exp_cap, exp_q <= ExpoCapNs, "exposure above frame-time cap")
  `AEGS_ASSERT_NEXT(a_accept_starts, s_axis_tvalid_i && s_axis_tready_o,
                    state_q == StUpkeep, "accepted item did not start upkeep")
  `AEGS_ASSERT_IMPL(a_result_from_done, $rose(out_valid_q), $past(state_q == StDone),
                    "result loaded outside the done step")
  `AEGS_ASSERT_NEXT(a_flag_cleared, state_q == StDone && out_free,
                    !dirty_q && state_q == StIdle, "changed flag not cleared on report")

endmodule

// ===== verif/tb_auto_exposure_gain_step_core.sv =====
// Self-checking bench for the auto exposure and gain controller. Frame luma
// items are queued by the stimulus process and fed into the input stream by a
// clocked driver. Every accepted item is run through a bit-accurate model of
// the controller kept in this file, and the predicted settings are queued.
// A clocked monitor takes result items off the output stream and compares
// them field by field against the oldest prediction. Both stream sides
// insert random idle bursts, except in the final phase. The receiver also
// holds off once for a long stretch so that the block backs up.
module tb_auto_exposure_gain_step_core;
  timeunit 1ns;
  timeprecision 1ps;

  import aegs_pkg::*;

  // One result item as it appears on m_axis_tdata_o, lowest field last.
  typedef struct packed {
    logic            changed;
    logic [ExpW-1:0] exposure_ns;
    logic [IsoW-1:0] iso;
  } settings_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [InW-1:0]     s_axis_tdata_i = '0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [OutW-1:0]    m_axis_tdata_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;

  auto_exposure_gain_step_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Frames waiting to be sent and settings waiting to come back.
  logic [InW-1:0] pending_luma[$];
  settings_t      expected_settings[$];

  int  mismatch_count = 0;
  int  results_seen   = 0;
  // Set for the final phase, which runs with no idle cycles on either side.
  bit  late_phase     = 1'b0;

  // Shadow copy of the configuration registers.
  logic [63:0] iso_lo_c   = '0;
  logic [63:0] iso_hi_c   = '0;
  logic [63:0] expo_lo_c  = '0;
  logic [63:0] expo_hi_c  = '0;
  logic [63:0] target_c   = 64'(TargetReset);

  // Shadow copy of the controller state.
  logic [63:0]        gain_q   = '0;
  logic [63:0]        expo_q   = 64'(MainsNs);
  logic [SettleW-1:0] settle_q = '0;
  logic               dirty_q  = 1'b1;

  function automatic logic [63:0] clamp_u64(input logic [63:0] v, lo, hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  // Truncated square root, built one result bit at a time from the top.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 21; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Exposure is only limited once its maximum is set; the 33 ms cap wins
  // over an exposure minimum that lies above it. ISO likewise needs a max.
  task automatic apply_limits();
    if (expo_hi_c != 0) begin
      expo_q = clamp_u64(expo_q, expo_lo_c, expo_hi_c);
      if (expo_q > 64'(ExpoCapNs)) expo_q = 64'(ExpoCapNs);
    end
    if (iso_hi_c != 0) gain_q = clamp_u64(gain_q, iso_lo_c, iso_hi_c);
  endtask

  // Advances the shadow state by one frame and returns the settings that
  // the block must report for it.
  task automatic predict_settings(input logic [InW-1:0] luma, output settings_t res);
    logic [63:0] err;
    logic [63:0] root;
    logic [63:0] prev_gain;
    logic [63:0] prev_expo;
    // A gain of zero means it was never seeded; seed it from ISO 400.
    if (iso_hi_c != 0 && gain_q == 0) gain_q = clamp_u64(64'(IsoStart), iso_lo_c, iso_hi_c);
    apply_limits();
    // Frames with unset limits or a luma of at most one half are skipped
    // without touching the settle counter.
    if (iso_hi_c != 0 && expo_hi_c != 0 && luma > LumaHalf) begin
      if (settle_q != 0) settle_q = settle_q - 1'b1;
      if (settle_q == 0) begin
        settle_q = SettleItems;
        err = (target_c << 16) / 64'(luma);
        if (err > 64'(ErrMax)) err = 64'(ErrMax);
        // Inside the dead band nothing moves; the edges themselves act.
        if (!(err > 64'(BandLo) && err < 64'(BandHi))) begin
          prev_gain = gain_q;
          prev_expo = expo_q;
          root   = floor_sqrt(err << 16);
          gain_q = clamp_u64((gain_q * root + 64'h8000) >> 16, iso_lo_c, iso_hi_c);
          apply_limits();
          // Gain pinned: exposure steps by 10 ms, or halves if at most 10 ms.
          if (gain_q >= iso_hi_c && err >= 64'(BandHi)) begin
            expo_q = expo_q + 64'(MainsNs);
            if (expo_q > 64'(ExpoCapNs)) expo_q = 64'(ExpoCapNs);
          end else if (gain_q <= iso_lo_c && err <= 64'(BandLo)) begin
            expo_q = (expo_q > 64'(MainsNs)) ? expo_q - 64'(MainsNs) : expo_q >> 1;
          end
          apply_limits();
          if (gain_q != prev_gain || expo_q != prev_expo) dirty_q = 1'b1;
        end
      end
    end
    res.iso         = gain_q[IsoW-1:0];
    res.exposure_ns = expo_q[ExpW-1:0];
    res.changed     = dirty_q;
    dirty_q = 1'b0;
  endtask

  // Driver: holds an offered item until it is taken, otherwise either idles
  // for a random burst or offers the next queued frame.
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      send_gap = 0;
    end else begin : drive
      settings_t res;
      logic      taken;
      taken = s_axis_tvalid_i && s_axis_tready_o;
      if (taken) begin
        predict_settings(s_axis_tdata_i, res);
        expected_settings.push_back(res);
        void'(pending_luma.pop_front());
      end
      if (s_axis_tvalid_i && !taken) begin
        // Keep the same item on the bus until the block takes it.
      end else if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_luma.size() != 0 && !late_phase && $urandom_range(3) == 0) begin
        // This cycle begins an idle burst; send_gap holds the rest of its length.
        send_gap = $urandom_range(5);
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_luma.size() != 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= pending_luma[0];
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks every result item, then decides whether to stall. Once,
  // after 150 results, it refuses results for the long_hold stretch while the
  // driver keeps offering frames, which fills the output register and the core.
  int  recv_gap  = 0;
  int  long_hold = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      recv_gap = 0;
    end else begin : watch
      settings_t got;
      settings_t want;
      logic      ready_next;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o[OutUsedW-1:0];
        results_seen++;
        if (expected_settings.size() == 0) begin
          $error("result item with none expected: iso %0d, exposure_ns %0d, changed %0d",
                 got.iso, got.exposure_ns, got.changed);
          mismatch_count++;
        end else begin
          want = expected_settings.pop_front();
          if (got.iso !== want.iso) begin
            $error("iso: expected %0d, actual %0d", want.iso, got.iso);
            mismatch_count++;
          end
          if (got.exposure_ns !== want.exposure_ns) begin
            $error("exposure_ns: expected %0d, actual %0d", want.exposure_ns, got.exposure_ns);
            mismatch_count++;
          end
          if (got.changed !== want.changed) begin
            $error("changed: expected %0d, actual %0d", want.changed, got.changed);
            mismatch_count++;
          end
        end
      end
      if (results_seen == 150 && !hold_done) begin
        hold_done = 1'b1;
        long_hold = 400;
      end
      if (long_hold > 0) begin
        long_hold--;
        ready_next = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        ready_next = 1'b0;
      end else if (!late_phase && $urandom_range(3) == 0) begin
        recv_gap = $urandom_range(5);
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      m_axis_tready_i <= ready_next;
    end
  end

  task automatic add_frames(input logic [InW-1:0] luma, input int count);
    repeat (count) pending_luma.push_back(luma);
  endtask

  // Half the frames have a luma around the target, so the gain and the
  // exposure walk toward their limits; the rest are dark frames, extremes,
  // band-edge values and plain noise.
  task automatic add_random_frames(input int count);
    logic [63:0] luma;
    logic [63:0] base;
    repeat (count) begin
      case ($urandom_range(9))
        0: luma = $urandom_range(LumaHalf);
        1: begin
          case ($urandom_range(3))
            0: luma = 64'(LumaHalf) + 1;
            1: luma = 64'hFFFF;
            2: luma = 0;
            default: luma = 64'(LumaHalf);
          endcase
        end
        2, 3: luma = $urandom_range(16'hFFFF);
        // With a target of 15237 these land on or right beside the band edges.
        4: luma = (($urandom_range(1) == 0) ? 64'd16384 : 64'd14240) + $urandom_range(2) - 1;
        default: begin
          base = (target_c == 0) ? 64'd256 : target_c;
          luma = base * $urandom_range(256, 16) / 64;
          if (luma > 64'hFFFF) luma = 64'hFFFF;
        end
      endcase
      pending_luma.push_back(luma[InW-1:0]);
    end
  endtask

  // Waits until every queued frame has been sent and answered.
  task automatic wait_drained();
    while (pending_luma.size() != 0 || expected_settings.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CfgIsoMin: iso_lo_c  = 64'(value[IsoW-1:0]);
      CfgIsoMax: iso_hi_c  = 64'(value[IsoW-1:0]);
      CfgExpMin: expo_lo_c = 64'(value);
      CfgExpMax: expo_hi_c = 64'(value);
      CfgTarget: target_c  = 64'(value[LumaW-1:0]);
      default: ;
    endcase
  endtask

  // Rewrites all five registers; only called while the block is idle.
  task automatic program_limits(input logic [CfgW-1:0] iso_lo, iso_hi, expo_lo, expo_hi,
                                target);
    write_reg(CfgIsoMin, iso_lo);
    write_reg(CfgIsoMax, iso_hi);
    write_reg(CfgExpMin, expo_lo);
    write_reg(CfgExpMax, expo_hi);
    write_reg(CfgTarget, target);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Limits still unset after reset: every frame is skipped, and the first
    // result still carries the changed flag from reset.
    add_frames(16'd0, 1);
    add_frames(LumaHalf, 1);
    add_frames(16'hFFFF, 1);
    wait_drained();

    // Ordinary limits. A dark frame at exactly one half, the darkest frame
    // that counts, then a settle window of saturated white and one of a
    // very dark scene that drives the gain to its maximum.
    program_limits(30'd100, 30'd1600, 30'd1_000_000, 30'd33_000_000, 30'(TargetReset));
    add_frames(LumaHalf, 1);
    add_frames(LumaHalf + 16'd1, 1);
    add_frames(16'hFFFF, 6);
    add_frames(16'd256, 6);
    wait_drained();

    // Inverted limits on both ranges and the largest target: the error
    // saturates, the minimums win and the exposure cap still holds.
    program_limits(30'd2000, 30'd1000, 30'd40_000_000, 30'd20_000_000, 30'd65535);
    add_frames(LumaHalf + 16'd1, 6);
    wait_drained();

    // Widest ranges; the exposure maximum lies far above the cap.
    program_limits(30'd0, 30'd65535, 30'd0, 30'd1_000_000_000, 30'(TargetReset));
    add_random_frames(110);
    wait_drained();

    // Both ranges collapsed to a single value.
    program_limits(30'd400, 30'd400, 30'd10_000_000, 30'd10_000_000,
                   30'($urandom_range(65535, 1)));
    add_random_frames(110);
    wait_drained();

    // ISO maximum unset: only the exposure limits are kept up.
    program_limits(30'd300, 30'd0, 30'd2_000_000, 30'd25_000_000, 30'(TargetReset));
    add_random_frames(40);
    wait_drained();

    // Exposure maximum unset: the gain is kept in range, nothing reacts.
    program_limits(30'd100, 30'd3200, 30'd0, 30'd0, 30'(TargetReset));
    add_random_frames(40);
    wait_drained();

    // Target chosen so that band-edge frames give errors on the edges.
    program_limits(30'd50, 30'd6400, 30'd500_000, 30'd33_000_000, 30'd15237);
    add_random_frames(110);
    wait_drained();

    // A zero target gives a zero error, always below the band.
    program_limits(30'd100, 30'd1600, 30'd1_000_000, 30'd33_000_000, 30'd0);
    add_random_frames(110);
    wait_drained();

    // Smallest nonzero target.
    program_limits(30'd0, 30'd800, 30'd0, 30'd33_000_000, 30'd1);
    add_random_frames(110);
    wait_drained();

    // Fully random settings, run back to back without idle cycles.
    program_limits(30'($urandom_range(3000)), 30'($urandom_range(65535)),
                   30'($urandom_range(20_000_000)), 30'($urandom_range(1_000_000_000)),
                   30'($urandom_range(65535, 1)));
    late_phase = 1'b1;
    add_random_frames(110);
    wait_drained();

    // Any stray result would show up within the longest item latency.
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/aegs_pkg.sv
hdl/aegs_alu.sv
hdl/auto_exposure_gain_step_core.sv
verif/tb_auto_exposure_gain_step_core.sv
